// ----- rtl/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared widths, calibration reset values, register indexes and the
// calibration word bundle of the barometer compensation core.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int COEF_W = 16;
    localparam int RAW_W  = 24;
    localparam int PRES_W = 24;
    localparam int TEMP_W = 19;
    localparam int IDX_W  = 3;

    // Stage count from accepted transaction to result register
    localparam int PIPE_DEPTH = 8;

    localparam logic [COEF_W-1:0] C1_RESET = 16'd31860;
    localparam logic [COEF_W-1:0] C2_RESET = 16'd27726;
    localparam logic [COEF_W-1:0] C3_RESET = 16'd37783;
    localparam logic [COEF_W-1:0] C4_RESET = 16'd16107;
    localparam logic [COEF_W-1:0] C5_RESET = 16'd33809;
    localparam logic [COEF_W-1:0] C6_RESET = 16'd28079;

    localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 19'sd2000;

    typedef enum logic [IDX_W-1:0] {
        IDX_PRESSURE_SENSITIVITY    = 3'd0,
        IDX_PRESSURE_OFFSET         = 3'd1,
        IDX_SENS_TEMP_COEFFICIENT   = 3'd2,
        IDX_OFFSET_TEMP_COEFFICIENT = 3'd3,
        IDX_REFERENCE_TEMPERATURE   = 3'd4,
        IDX_TEMPERATURE_COEFFICIENT = 3'd5
    } bpc_reg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] pressure_sensitivity;
        logic [COEF_W-1:0] pressure_offset;
        logic [COEF_W-1:0] sens_temp_coefficient;
        logic [COEF_W-1:0] offset_temp_coefficient;
        logic [COEF_W-1:0] reference_temperature;
        logic [COEF_W-1:0] temperature_coefficient;
    } bpc_coef_t;

endpackage

// ----- rtl/baro_pressure_temp_compensation_core.sv -----
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation_core
// First-order barometer compensation: raw pressure and temperature
// conversions in, pascals and hundredths of a degree out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries one raw conversion pair
//   (pressure_raw, temperature_raw); a transaction completes on a clock
//   edge with in_valid high and in_stall low.
//   Output channel out_valid/out_stall carries pressure_pa and
//   temperature_centi, held steady while out_stall is high.
//   Calibration words are written through cfg_wr_en/cfg_index/cfg_data,
//   index 0..5 in calibration word order; the user must write them only
//   while the core is idle; the core does not enforce this. One pair is
//   taken every cycle while in_stall is low, set by the eight-stage pipeline
//   with one product stage for the dT terms and a split D1 * SENS multiply.
//   Reset empties the pipeline and loads the default calibration words.
//   A stall on the output holds the result; empty stages upstream still
//   fill, and in_stall rises only when all eight stages hold a transaction.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [bpc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [bpc_pkg::COEF_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bpc_pkg::RAW_W-1:0]         pressure_raw,
    input  logic [bpc_pkg::RAW_W-1:0]         temperature_raw,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bpc_pkg::PRES_W-1:0] pressure_pa,
    output logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi
);
    import bpc_pkg::*;

    bpc_coef_t coef;

    bpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    bpc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .coef              (coef),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .pressure_raw      (pressure_raw),
        .temperature_raw   (temperature_raw),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .pressure_pa       (pressure_pa),
        .temperature_centi (temperature_centi)
    );

    // Back-pressure on the input can only come from a blocked result
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a blocked result");

    // Compensated temperature stays inside the reachable range
    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (temperature_centi >= -19'sd131072)
                   && (temperature_centi <= 19'sd135168))
        else $error("temperature result out of range");

endmodule

// ----- rtl/bpc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// bpc_cfg_regs
// Calibration word register file with a plain write port; writes to
// unused indexes are dropped.
// ----------------------------------------------------------------------------
module bpc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bpc_pkg::IDX_W-1:0]      cfg_index,
    input  logic [bpc_pkg::COEF_W-1:0]     cfg_data,
    output bpc_pkg::bpc_coef_t             coef
);
    import bpc_pkg::*;

    bpc_coef_t coef_reg;
    bpc_coef_t coef_next;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                IDX_PRESSURE_SENSITIVITY:    coef_next.pressure_sensitivity    = cfg_data;
                IDX_PRESSURE_OFFSET:         coef_next.pressure_offset         = cfg_data;
                IDX_SENS_TEMP_COEFFICIENT:   coef_next.sens_temp_coefficient   = cfg_data;
                IDX_OFFSET_TEMP_COEFFICIENT: coef_next.offset_temp_coefficient = cfg_data;
                IDX_REFERENCE_TEMPERATURE:   coef_next.reference_temperature   = cfg_data;
                IDX_TEMPERATURE_COEFFICIENT: coef_next.temperature_coefficient = cfg_data;
                default:                     coef_next = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.pressure_sensitivity    <= C1_RESET;
            coef_reg.pressure_offset         <= C2_RESET;
            coef_reg.sens_temp_coefficient   <= C3_RESET;
            coef_reg.offset_temp_coefficient <= C4_RESET;
            coef_reg.reference_temperature   <= C5_RESET;
            coef_reg.temperature_coefficient <= C6_RESET;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ----- rtl/bpc_datapath.sv -----
// ----------------------------------------------------------------------------
// bpc_datapath
// Eight-stage compensation pipeline with per-stage valid bits and a
// bubble-collapsing stall chain.
// ----------------------------------------------------------------------------
module bpc_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  bpc_pkg::bpc_coef_t                coef,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [bpc_pkg::RAW_W-1:0]         pressure_raw,
    input  logic [bpc_pkg::RAW_W-1:0]         temperature_raw,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [bpc_pkg::PRES_W-1:0] pressure_pa,
    output logic signed [bpc_pkg::TEMP_W-1:0] temperature_centi
);
    import bpc_pkg::*;

    localparam logic signed [40:0] PRES_MAX = 41'sd8388607;
    localparam logic signed [40:0] PRES_MIN = -41'sd8388608;

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] valid_next;
    logic [PIPE_DEPTH-1:0] en;

    // Stage 1: temperature difference
    logic        [23:0] d1_s1_reg, d1_s1_next;
    logic signed [24:0] dt_s1_reg, dt_s1_next;
    // Stage 2: the three dT products
    logic        [23:0] d1_s2_reg;
    logic signed [41:0] off_prod_s2_reg, off_prod_s2_next;
    logic signed [41:0] sens_prod_s2_reg, sens_prod_s2_next;
    logic signed [41:0] temp_prod_s2_reg, temp_prod_s2_next;
    // Stage 3: OFF, SENS, TEMP
    logic        [23:0] d1_s3_reg;
    logic signed [39:0] off_s3_reg, off_s3_next;
    logic signed [35:0] sens_s3_reg, sens_s3_next;
    logic signed [18:0] temp_s3_reg, temp_s3_next;
    // Stage 4: D1 * SENS as two partial products
    logic signed [39:0] off_s4_reg;
    logic signed [18:0] temp_s4_reg;
    logic        [41:0] pp_lo_s4_reg, pp_lo_s4_next;
    logic signed [42:0] pp_hi_s4_reg, pp_hi_s4_next;
    // Stage 5: full product
    logic signed [39:0] off_s5_reg;
    logic signed [18:0] temp_s5_reg;
    logic signed [60:0] prod_s5_reg, prod_s5_next;
    // Stage 6: product / 2^21 toward zero
    logic signed [39:0] off_s6_reg;
    logic signed [18:0] temp_s6_reg;
    logic signed [39:0] quot_s6_reg, quot_s6_next;
    // Stage 7: subtract offset
    logic signed [18:0] temp_s7_reg;
    logic signed [40:0] diff_s7_reg, diff_s7_next;
    // Stage 8: result register
    logic signed [23:0] pres_s8_reg, pres_s8_next;
    logic signed [18:0] temp_s8_reg;

    logic signed [41:0] off_sh, sens_sh, temp_adj, temp_sh;
    logic signed [60:0] quot_adj, quot_sh;
    logic signed [40:0] diff_adj, pres_full;

    // A stage takes new data when empty or when the stage after it moves
    always_comb
    begin
        en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || !out_stall;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int i = 1; i < PIPE_DEPTH; i++)
        begin
            if (en[i])
            begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_comb
    begin
        d1_s1_next = pressure_raw;
        dt_s1_next = $signed({1'b0, temperature_raw})
                   - $signed({1'b0, coef.reference_temperature, 8'd0});

        off_prod_s2_next  = dt_s1_reg * $signed({1'b0, coef.offset_temp_coefficient});
        sens_prod_s2_next = dt_s1_reg * $signed({1'b0, coef.sens_temp_coefficient});
        temp_prod_s2_next = dt_s1_reg * $signed({1'b0, coef.temperature_coefficient});

        // Arithmetic shifts floor; the temperature quotient truncates
        off_sh       = off_prod_s2_reg >>> 5;
        sens_sh      = sens_prod_s2_reg >>> 7;
        off_s3_next  = $signed({6'd0, coef.pressure_offset, 18'd0}) + $signed(off_sh[39:0]);
        sens_s3_next = $signed({3'd0, coef.pressure_sensitivity, 17'd0})
                     + $signed(sens_sh[35:0]);
        temp_adj     = temp_prod_s2_reg
                     + $signed({19'd0, {23{temp_prod_s2_reg[41]}}});
        temp_sh      = temp_adj >>> 23;
        temp_s3_next = $signed(temp_sh[18:0]) + TEMP_OFFSET;

        pp_lo_s4_next = d1_s3_reg * sens_s3_reg[17:0];
        pp_hi_s4_next = $signed({1'b0, d1_s3_reg}) * $signed(sens_s3_reg[35:18]);

        prod_s5_next = $signed({pp_hi_s4_reg, 18'd0}) + $signed({19'd0, pp_lo_s4_reg});

        quot_adj     = prod_s5_reg + $signed({40'd0, {21{prod_s5_reg[60]}}});
        quot_sh      = quot_adj >>> 21;
        quot_s6_next = $signed(quot_sh[39:0]);

        diff_s7_next = $signed({quot_s6_reg[39], quot_s6_reg})
                     - $signed({off_s6_reg[39], off_s6_reg});

        diff_adj  = diff_s7_reg + $signed({26'd0, {15{diff_s7_reg[40]}}});
        pres_full = diff_adj >>> 15;
        if (pres_full > PRES_MAX)
        begin
            pres_s8_next = 24'sh7FFFFF;
        end
        else if (pres_full < PRES_MIN)
        begin
            pres_s8_next = 24'sh800000;
        end
        else
        begin
            pres_s8_next = $signed(pres_full[23:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            d1_s1_reg <= d1_s1_next;
            dt_s1_reg <= dt_s1_next;
        end
        if (en[1])
        begin
            d1_s2_reg        <= d1_s1_reg;
            off_prod_s2_reg  <= off_prod_s2_next;
            sens_prod_s2_reg <= sens_prod_s2_next;
            temp_prod_s2_reg <= temp_prod_s2_next;
        end
        if (en[2])
        begin
            d1_s3_reg   <= d1_s2_reg;
            off_s3_reg  <= off_s3_next;
            sens_s3_reg <= sens_s3_next;
            temp_s3_reg <= temp_s3_next;
        end
        if (en[3])
        begin
            off_s4_reg   <= off_s3_reg;
            temp_s4_reg  <= temp_s3_reg;
            pp_lo_s4_reg <= pp_lo_s4_next;
            pp_hi_s4_reg <= pp_hi_s4_next;
        end
        if (en[4])
        begin
            off_s5_reg  <= off_s4_reg;
            temp_s5_reg <= temp_s4_reg;
            prod_s5_reg <= prod_s5_next;
        end
        if (en[5])
        begin
            off_s6_reg  <= off_s5_reg;
            temp_s6_reg <= temp_s5_reg;
            quot_s6_reg <= quot_s6_next;
        end
        if (en[6])
        begin
            temp_s7_reg <= temp_s6_reg;
            diff_s7_reg <= diff_s7_next;
        end
        if (en[7])
        begin
            pres_s8_reg <= pres_s8_next;
            temp_s8_reg <= temp_s7_reg;
        end
    end

    assign in_stall          = !en[0];
    assign out_valid         = valid_reg[PIPE_DEPTH-1];
    assign pressure_pa       = pres_s8_reg;
    assign temperature_centi = temp_s8_reg;

endmodule
